[hw/rtl/plir_pkg.sv]
`default_nettype none
package plir_pkg;

    localparam logic [2:0] REQ_APPEND       = 3'd0;
    localparam logic [2:0] REQ_INSERT       = 3'd1;
    localparam logic [2:0] REQ_REMOVE_AT    = 3'd2;
    localparam logic [2:0] REQ_REMOVE_VALUE = 3'd3;
    localparam logic [2:0] REQ_CLEAR        = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BADPOS   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [4:0]  position;
        logic [31:0] item_value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] removed_value;
        logic [4:0]  item_count;
    } t_out_word;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CMP,
        CELL_INSERT,
        CELL_REMOVE
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     by_value;
    } t_cell_ctl;

endpackage
`default_nettype wire

[hw/rtl/plir_cell.sv]
`default_nettype none
module plir_cell #(
    parameter int IDX = 0,
    parameter int DW  = 32,
    parameter int CW  = 5,
    parameter int PW  = 5
) (
    input  wire                   i_clk,
    input  plir_pkg::t_cell_ctl   i_ctl,
    input  wire  [PW-1:0]         i_pos,
    input  wire  [CW-1:0]         i_count,
    input  wire  [DW-1:0]         i_val,
    input  wire  [DW-1:0]         i_prev_entry,
    input  wire  [DW-1:0]         i_next_entry,
    input  wire                   i_prev_hit,
    output logic [DW-1:0]         o_entry,
    output logic                  o_hit,
    output logic [DW-1:0]         o_take
);
    import plir_pkg::*;

    logic [DW-1:0] r_entry;
    logic [DW-1:0] n_entry;
    logic          r_match;
    logic          n_match;

    always_comb begin
        n_entry = r_entry;
        n_match = r_match;
        case (i_ctl.op)
            CELL_CMP: begin
                if (i_ctl.by_value) begin
                    n_match = (r_entry == i_val) && (32'(i_count) > IDX);
                end else begin
                    n_match = (32'(i_pos) == IDX);
                end
            end
            CELL_INSERT: begin
                // a hit below means this cell sits past the insert point
                if (i_prev_hit) begin
                    n_entry = i_prev_entry;
                end else if (r_match) begin
                    n_entry = i_val;
                end
            end
            CELL_REMOVE: begin
                if (i_prev_hit || r_match) begin
                    n_entry = i_next_entry;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_match <= n_match;
    end

    assign o_entry = r_entry;
    assign o_hit   = i_prev_hit | r_match;
    // only the lowest matching cell hands out its word
    assign o_take  = (r_match && !i_prev_hit) ? r_entry : '0;

endmodule
`default_nettype wire

[hw/rtl/positional_list_insert_remove.sv]
// Each request runs an accept step, a compare pass and an update pass over
// the shifting cell row; the result word is written to the output register
// by the update pass, and no new request is taken before it completes.
// The update pass waits only while the output register is held by o-side stall.
// Reset (synchronous, active low) empties the list and drops any result.
`default_nettype none
module positional_list_insert_remove #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  plir_pkg::t_in_word  i_in_word,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output plir_pkg::t_out_word o_out_word,
    input  wire                 i_out_stall
);
    import plir_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 5) ? CW : 5;

    t_state        r_state;
    t_state        n_state;
    t_in_word      r_req;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    t_out_word     r_out;

    t_cell_ctl       cell_ctl;
    t_cell_op        exec_op;
    logic [PW-1:0]   bpos;
    logic [DATA_WIDTH-1:0] val_dw;
    logic [1:0]      status;
    logic            take_out;
    logic            fire;
    logic            found;
    logic [DATA_WIDTH-1:0] removed_dw;

    logic [DATA_WIDTH-1:0] entry [DEPTH];
    logic [DATA_WIDTH-1:0] take  [DEPTH];
    logic                  hit   [DEPTH+1];

    assign val_dw = DATA_WIDTH'(r_req.item_value);
    assign hit[0] = 1'b0;
    assign found  = hit[DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] prev_entry;
        logic [DATA_WIDTH-1:0] next_entry;
        if (g == 0) begin : g_first
            assign prev_entry = '0;
        end else begin : g_mid
            assign prev_entry = entry[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign next_entry = '0;
        end else begin : g_inner
            assign next_entry = entry[g+1];
        end
        plir_cell #(
            .IDX (g),
            .DW  (DATA_WIDTH),
            .CW  (CW),
            .PW  (PW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl),
            .i_pos        (bpos),
            .i_count      (r_count),
            .i_val        (val_dw),
            .i_prev_entry (prev_entry),
            .i_next_entry (next_entry),
            .i_prev_hit   (hit[g]),
            .o_entry      (entry[g]),
            .o_hit        (hit[g+1]),
            .o_take       (take[g])
        );
    end

    always_comb begin
        removed_dw = '0;
        for (int k = 0; k < DEPTH; k++) begin
            removed_dw = removed_dw | take[k];
        end
    end

    always_comb begin
        n_state           = r_state;
        n_count           = r_count;
        status            = ST_OK;
        exec_op           = CELL_HOLD;
        take_out          = 1'b0;
        cell_ctl.op       = CELL_HOLD;
        cell_ctl.by_value = (r_req.req_type == REQ_REMOVE_VALUE);
        bpos = (r_req.req_type == REQ_APPEND) ? PW'(r_count) : PW'(r_req.position);

        unique case (r_req.req_type)
            REQ_APPEND: begin
                if (r_count >= CW'(DEPTH)) begin
                    status = ST_FULL;
                end else begin
                    exec_op = CELL_INSERT;
                    n_count = CW'(r_count + 1'b1);
                end
            end
            REQ_INSERT: begin
                if (PW'(r_req.position) > PW'(r_count)) begin
                    status = ST_BADPOS;
                end else if (r_count >= CW'(DEPTH)) begin
                    status = ST_FULL;
                end else begin
                    exec_op = CELL_INSERT;
                    n_count = CW'(r_count + 1'b1);
                end
            end
            REQ_REMOVE_AT: begin
                if (PW'(r_req.position) >= PW'(r_count)) begin
                    status = ST_BADPOS;
                end else begin
                    exec_op  = CELL_REMOVE;
                    take_out = 1'b1;
                    n_count  = CW'(r_count - 1'b1);
                end
            end
            REQ_REMOVE_VALUE: begin
                if (!found) begin
                    status = ST_NOTFOUND;
                end else begin
                    exec_op  = CELL_REMOVE;
                    take_out = 1'b1;
                    n_count  = CW'(r_count - 1'b1);
                end
            end
            REQ_CLEAR: begin
                n_count = '0;
            end
            default: begin
                status = ST_BADPOS;
            end
        endcase

        fire = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                cell_ctl.op = CELL_CMP;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                // hold the cells until the output register can take the word
                if (fire) begin
                    cell_ctl.op = exec_op;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_req <= i_in_word;
        end
        if (fire) begin
            r_out.status        <= status;
            r_out.removed_value <= take_out ? 32'(removed_dw) : 32'd0;
            r_out.item_count    <= 5'(n_count);
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_CMP))
        else $error("accepted word did not start the compare pass");

    a_result_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_EXEC))
        else $error("result word without an update pass");

endmodule
`default_nettype wire
